>>> design/circular_next_marked_distance_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the circular next-mark distance block
// Shared property wrappers; each expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef CIRCULAR_NEXT_MARKED_DISTANCE_MACROS_SVH
`define CIRCULAR_NEXT_MARKED_DISTANCE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define CNMD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CNMD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/cnmd_pkg.sv
// ---------------------------------------------------------------------------
// cnmd_pkg
// Sizes, request codes and shared types of the circular next-mark block.
// ---------------------------------------------------------------------------
package cnmd_pkg;

  localparam int MAX_POSITIONS = 1024;
  localparam int POS_W = $clog2(MAX_POSITIONS);
  localparam int N_W = POS_W + 1;

  // Fixed field widths
  localparam int RING_W = 11;
  localparam int KIND_W = 2;
  localparam int POSN_W = 11;
  localparam int STEP_W = 30;
  localparam int DIST_W = 10;

  localparam int IN_TDATA_W = ((POSN_W + STEP_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DIST_W + 7) / 8) * 8;

  localparam logic [RING_W-1:0] RING_RESET = 11'd1024;

  // Remainder unit
  localparam int DIV_W = STEP_W + 1;
  localparam int ITER_W = $clog2(DIV_W + 1);

  // Mark store organization
  localparam int WORD_W = 32;
  localparam int WBIT_W = $clog2(WORD_W);
  localparam int NWORDS = (MAX_POSITIONS + WORD_W - 1) / WORD_W;
  localparam int WADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int NW_W = WADDR_W + 1;
  localparam int IDX_W = WADDR_W + WBIT_W;
  localparam int EXT_W = ((IDX_W > N_W) ? IDX_W : N_W) + 1;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_TOGGLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MOVE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  typedef struct packed {
    logic             start;
    logic             short_op;
    logic [DIV_W-1:0] dividend;
    logic [N_W-1:0]   divisor;
  } rem_req_t;

  typedef struct packed {
    logic           busy;
    logic           done;
    logic [N_W-1:0] rem;
  } rem_rsp_t;

  // Ring length in use: zero acts as one, clamp to the store size.
  function automatic logic [N_W-1:0] ring_len(input logic [RING_W-1:0] size);
    logic [N_W-1:0] len;
    if (size == '0) begin
      len = N_W'(1);
    end else if (int'(size) > MAX_POSITIONS) begin
      len = N_W'(MAX_POSITIONS);
    end else begin
      len = N_W'(size);
    end
    return len;
  endfunction

endpackage

>>> design/cnmd_rem.sv
// ---------------------------------------------------------------------------
// cnmd_rem
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// ---------------------------------------------------------------------------
`include "circular_next_marked_distance_macros.svh"

module cnmd_rem import cnmd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  rem_req_t req,
  output rem_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [ITER_W-1:0] cnt_r;
  logic [DIV_W-1:0]  dvd_r;
  logic [N_W-1:0]    rem_r;
  logic [N_W-1:0]    div_r;

  logic [N_W:0]      trial;
  logic              take;
  logic [N_W-1:0]    rem_nxt;

  always_comb begin
    trial   = {rem_r, dvd_r[DIV_W-1]};
    take    = (trial >= {1'b0, div_r});
    rem_nxt = take ? N_W'(trial - {1'b0, div_r}) : trial[N_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.short_op ? ITER_W'(POS_W) : ITER_W'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - ITER_W'(1);
        if (cnt_r == ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Short requests carry only the low index bits: left-align them.
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.short_op ? (req.dividend << (DIV_W - POS_W)) : req.dividend;
      rem_r <= '0;
      div_r <= req.divisor;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

  `CNMD_ASSERT_NEXT(a_start_busy, req.start, busy_r, "remainder unit did not start")
  `CNMD_ASSERT_NOW(a_done_range, done_r, rem_r < div_r, "remainder not below divisor")
  `CNMD_ASSERT_NOW(a_busy_cnt, busy_r, cnt_r != '0, "remainder unit busy with zero count")

endmodule

>>> design/circular_next_marked_distance.sv
// ---------------------------------------------------------------------------
// circular_next_marked_distance
// Ring of marked positions with toggle, move and next-mark distance query.
// ---------------------------------------------------------------------------
//
//   channel   dir   handshake              payload
//   in_       in    in_tvalid/in_tready    tdata: position, step; tuser: kind
//   out_      out   out_tvalid/out_tready  tdata: distance; tuser: none_marked
//   cfg_      in    cfg_wr_en              cfg_wr_data: ring_size
//
// Steps: a toggle reads the mark word, then writes it back with one bit
// flipped. A move runs the bit-serial remainder unit over all 31 dividend bits.
// A query first reduces the current position in the remainder unit, then
// scans the 32-bit mark words in ring order and posts the result.
// A query with no marks at all skips both steps and posts its result.
// Reset: synchronous, active low; mark words read as zero until written.
// Stalls: a result waits in the output register; the block takes other
// requests meanwhile, and a later query holds only in its final state.
// ---------------------------------------------------------------------------
`include "circular_next_marked_distance_macros.svh"

module circular_next_marked_distance import cnmd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input request channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [10:0] position, [40:11] step, zero pad
  input  logic [KIND_W-1:0]      in_tuser,   // [1:0] kind
  // Result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [9:0] distance, zero pad
  output logic                   out_tuser,  // [0] none_marked
  // Configuration
  input  logic                   cfg_wr_en,
  input  logic [RING_W-1:0]      cfg_wr_data // ring_size
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TGL   = 3'd1;
  localparam logic [2:0] ST_MOVE  = 3'd2;
  localparam logic [2:0] ST_QMOD  = 3'd3;
  localparam logic [2:0] ST_QSCAN = 3'd4;
  localparam logic [2:0] ST_QRES  = 3'd5;

  // Registers
  logic [2:0]         state_r, state_nxt;
  logic [RING_W-1:0]  ring_size_r;
  logic [POS_W-1:0]   cur_r, cur_nxt;
  logic [POS_W-1:0]   c_r, c_nxt;
  logic [N_W-1:0]     mark_cnt_r, mark_cnt_nxt;
  logic [POS_W-1:0]   tgl_idx_r, tgl_idx_nxt;
  logic [NW_W-1:0]    issue_k_r, issue_k_nxt;
  logic               pend_r, pend_nxt;
  logic [NW_W-1:0]    pend_k_r, pend_k_nxt;
  logic [WADDR_W-1:0] pend_w_r, pend_w_nxt;
  logic               found_r, found_nxt;
  logic [IDX_W-1:0]   p_r, p_nxt;
  logic               out_valid_r;
  logic [DIST_W-1:0]  out_dist_r;
  logic               out_none_r;
  logic [WORD_W-1:0]  rd_data_r;
  logic               rd_vld_r;
  logic [NWORDS-1:0]  wvld_r;
  logic [WORD_W-1:0]  mem [NWORDS];

  // Combinational
  logic               in_acc;
  logic [KIND_W-1:0]  in_kind;
  logic [POSN_W-1:0]  in_pos;
  logic [STEP_W-1:0]  in_step;
  logic [N_W-1:0]     n, n_m1;
  logic [NW_W-1:0]    nw;
  logic [WBIT_W-1:0]  n_last_off;
  logic               pos_ok;
  logic [POS_W-1:0]   tgl_idx;
  rem_req_t           rem_req;
  rem_rsp_t           rem_rsp;
  logic               rd_en;
  logic [WADDR_W-1:0] rd_addr;
  logic               wr_en;
  logic [WADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0]  tgl_word;
  logic [WBIT_W-1:0]  tgl_off;
  logic [WORD_W-1:0]  wr_data;
  logic               tgl_bit;
  logic [NW_W-1:0]    cw;
  logic [NW_W:0]      wsum;
  logic [WADDR_W-1:0] scan_w;
  logic               issue_more;
  logic [WORD_W-1:0]  chk_word;
  logic [WBIT_W-1:0]  c_off;
  logic [WORD_W-1:0]  lo_base, hi_mask, sel_mask, hit;
  logic               chk_first, chk_last, chk_endw, any_hit;
  logic [WBIT_W-1:0]  fb;
  logic [EXT_W-1:0]   p_e, c_e, n_e, dist_e;
  logic               out_load;

  // Unpack the request
  assign in_acc  = in_tvalid & in_tready;
  assign in_kind = in_tuser;
  assign in_pos  = in_tdata[POSN_W-1:0];
  assign in_step = in_tdata[POSN_W+STEP_W-1:POSN_W];

  // Ring geometry in 32-bit mark words
  assign n          = ring_len(ring_size_r);
  assign n_m1       = n - N_W'(1);
  assign nw         = NW_W'(n_m1 >> WBIT_W) + NW_W'(1);
  assign n_last_off = WBIT_W'(n_m1);

  assign pos_ok  = (in_pos != '0) && (32'(in_pos) <= 32'(n));
  assign tgl_idx = POS_W'(in_pos - POSN_W'(1));

  // Toggle write-back: flip one bit of the word just read
  assign tgl_word = rd_vld_r ? rd_data_r : '0;
  assign tgl_off  = WBIT_W'(tgl_idx_r);
  assign tgl_bit  = tgl_word[tgl_off];
  assign wr_addr  = WADDR_W'(tgl_idx_r >> WBIT_W);
  assign wr_data  = tgl_word ^ (WORD_W'(1) << tgl_off);

  // Scan order: start word, then wrap round the ring back to it
  assign cw         = NW_W'(c_r >> WBIT_W);
  assign wsum       = {1'b0, cw} + {1'b0, issue_k_r};
  assign scan_w     = (wsum >= {1'b0, nw}) ? WADDR_W'(wsum - {1'b0, nw}) : WADDR_W'(wsum);
  assign issue_more = (issue_k_r <= nw);

  // Mask the word under check: first visit keeps bits at or past the current
  // position, the final wrap-around visit keeps bits before it, and the ring's
  // last word drops bits beyond the ring end.
  assign chk_word  = rd_vld_r ? rd_data_r : '0;
  assign c_off     = WBIT_W'(c_r);
  assign chk_first = (pend_k_r == '0);
  assign chk_last  = (pend_k_r == nw);
  assign chk_endw  = (NW_W'(pend_w_r) == (nw - NW_W'(1)));
  assign lo_base   = {WORD_W{1'b1}} << c_off;
  assign hi_mask   = chk_endw ? ({WORD_W{1'b1}} >> (~n_last_off)) : {WORD_W{1'b1}};
  assign sel_mask  = chk_first ? lo_base : (chk_last ? ~lo_base : {WORD_W{1'b1}});
  assign hit       = chk_word & hi_mask & sel_mask;
  assign any_hit   = |hit;

  // Lowest set bit of the masked word
  always_comb begin
    fb = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (hit[b]) begin
        fb = WBIT_W'(b);
      end
    end
  end

  // Clockwise distance from the current position to the hit
  always_comb begin
    p_e = EXT_W'(p_r);
    c_e = EXT_W'(c_r);
    n_e = EXT_W'(n);
    if (p_e >= c_e) begin
      dist_e = p_e - c_e;
    end else begin
      dist_e = p_e + n_e - c_e;
    end
  end

  cnmd_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    c_nxt        = c_r;
    mark_cnt_nxt = mark_cnt_r;
    tgl_idx_nxt  = tgl_idx_r;
    issue_k_nxt  = issue_k_r;
    pend_nxt     = pend_r;
    pend_k_nxt   = pend_k_r;
    pend_w_nxt   = pend_w_r;
    found_nxt    = found_r;
    p_nxt        = p_r;
    rem_req          = '0;
    rem_req.divisor  = n;
    rem_req.dividend = DIV_W'(cur_r);
    rd_en    = 1'b0;
    rd_addr  = WADDR_W'(tgl_idx >> WBIT_W);
    wr_en    = 1'b0;
    out_load = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_kind)
            KIND_TOGGLE: begin
              // Drop toggles outside the ring
              if (pos_ok) begin
                rd_en       = 1'b1;
                tgl_idx_nxt = tgl_idx;
                state_nxt   = ST_TGL;
              end
            end
            KIND_MOVE: begin
              rem_req.start    = 1'b1;
              rem_req.dividend = DIV_W'(cur_r) + DIV_W'(in_step);
              state_nxt        = ST_MOVE;
            end
            KIND_QUERY: begin
              if (mark_cnt_r == '0) begin
                found_nxt = 1'b0;
                state_nxt = ST_QRES;
              end else begin
                // Reduce the stored position first: the ring may have shrunk
                rem_req.start    = 1'b1;
                rem_req.short_op = 1'b1;
                state_nxt        = ST_QMOD;
              end
            end
            default: begin
              // Unknown kind: accept and drop
            end
          endcase
        end
      end
      ST_TGL: begin
        wr_en        = 1'b1;
        mark_cnt_nxt = tgl_bit ? (mark_cnt_r - N_W'(1)) : (mark_cnt_r + N_W'(1));
        state_nxt    = ST_IDLE;
      end
      ST_MOVE: begin
        if (rem_rsp.done) begin
          cur_nxt   = POS_W'(rem_rsp.rem);
          state_nxt = ST_IDLE;
        end
      end
      ST_QMOD: begin
        if (rem_rsp.done) begin
          c_nxt       = POS_W'(rem_rsp.rem);
          issue_k_nxt = '0;
          pend_nxt    = 1'b0;
          state_nxt   = ST_QSCAN;
        end
      end
      ST_QSCAN: begin
        // Issue one word read per cycle, check the word read last cycle
        if (issue_more) begin
          rd_en       = 1'b1;
          rd_addr     = scan_w;
          issue_k_nxt = issue_k_r + NW_W'(1);
        end
        pend_nxt   = issue_more;
        pend_k_nxt = issue_k_r;
        pend_w_nxt = scan_w;
        if (pend_r) begin
          if (any_hit) begin
            found_nxt = 1'b1;
            p_nxt     = {pend_w_r, fb};
            pend_nxt  = 1'b0;
            state_nxt = ST_QRES;
          end else if (chk_last) begin
            // Every mark lies outside the ring
            found_nxt = 1'b0;
            pend_nxt  = 1'b0;
            state_nxt = ST_QRES;
          end
        end
      end
      ST_QRES: begin
        // Hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ring_size_r <= RING_RESET;
      cur_r       <= '0;
      mark_cnt_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      wvld_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      cur_r      <= cur_nxt;
      mark_cnt_r <= mark_cnt_nxt;
      pend_r     <= pend_nxt;
      if (cfg_wr_en) begin
        ring_size_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (wr_en) begin
        wvld_r[wr_addr] <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    c_r       <= c_nxt;
    tgl_idx_r <= tgl_idx_nxt;
    issue_k_r <= issue_k_nxt;
    pend_k_r  <= pend_k_nxt;
    pend_w_r  <= pend_w_nxt;
    found_r   <= found_nxt;
    p_r       <= p_nxt;
    if (out_load) begin
      out_dist_r <= found_r ? DIST_W'(dist_e) : '0;
      out_none_r <= ~found_r;
    end
  end

  // Mark store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= wvld_r[rd_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_dist_r);
  assign out_tuser  = out_none_r;

  `CNMD_ASSERT_NEXT(a_tgl_count, state_r == ST_TGL, mark_cnt_r != $past(mark_cnt_r), "toggle left mark count unchanged")
  `CNMD_ASSERT_NEXT(a_empty_query, in_acc && (in_kind == KIND_QUERY) && (mark_cnt_r == '0), state_r == ST_QRES, "empty query did not post at once")
  `CNMD_ASSERT_NOW(a_dist_range, (state_r == ST_QRES) && found_r, dist_e < n_e, "distance outside the ring")
  `CNMD_ASSERT_NOW(a_count_max, 1'b1, mark_cnt_r <= N_W'(MAX_POSITIONS), "mark count above store size")

endmodule
